@@ rtl/assert_macros.svh @@
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, off while reset is held
`define RBS_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// implication checked in the next cycle, off while reset is held
`define RBS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

// implication checked in the next cycle, also during reset
`define RBS_ASSERT_ALWAYS(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/rbs_pkg.sv @@
package rbs_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_AXES        = 3;
endpackage

@@ rtl/rbs_if.sv @@
interface rbs_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                output ready);
endinterface

interface rbs_out_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] t_entry;
  logic signed [COORD_WIDTH-1:0] t_exit;
  modport source (output valid, hit, t_entry, t_exit, input ready);
  modport sink (input valid, hit, t_entry, t_exit, output ready);
endinterface

@@ rtl/rbs_div.sv @@
// unsigned restoring divider, one quotient bit per stage
module rbs_div
  import rbs_pkg::*;
#(
  parameter int NUM_WIDTH = 49,
  parameter int DEN_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NUM_WIDTH-1:0] num,
  input  logic [DEN_WIDTH-1:0] den,
  output logic [NUM_WIDTH-1:0] quo
);
  logic [NUM_WIDTH-1:0] acc_r [NUM_WIDTH];
  logic [DEN_WIDTH-1:0] rem_r [NUM_WIDTH];
  logic [DEN_WIDTH-1:0] den_r [NUM_WIDTH];

  genvar k;
  generate
    for (k = 0; k < NUM_WIDTH; k++) begin : g_stage
      logic [NUM_WIDTH-1:0] acc_in;
      logic [DEN_WIDTH-1:0] rem_in;
      logic [DEN_WIDTH-1:0] den_in;
      logic [DEN_WIDTH:0]   trial;
      logic                 ge;
      logic [DEN_WIDTH-1:0] rem_nxt;
      logic [NUM_WIDTH-1:0] acc_nxt;
      if (k == 0) begin : g_first
        assign acc_in = num;
        assign rem_in = '0;
        assign den_in = den;
      end else begin : g_next
        assign acc_in = acc_r[k-1];
        assign rem_in = rem_r[k-1];
        assign den_in = den_r[k-1];
      end
      always_comb begin
        trial   = {rem_in, acc_in[NUM_WIDTH-1]};
        ge      = trial >= {1'b0, den_in};
        rem_nxt = ge ? DEN_WIDTH'(trial - {1'b0, den_in}) : DEN_WIDTH'(trial);
        acc_nxt = {acc_in[NUM_WIDTH-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          acc_r[k] <= acc_nxt;
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
        end
      end
    end
  endgenerate

  assign quo = acc_r[NUM_WIDTH-1];
endmodule

@@ rtl/ray_box_slab_intersection.sv @@
// Ray versus axis-aligned box test by the slab method, one test per transfer, all
// coordinates signed fixed point (Q16.16 by default). Per axis, (bound - origin) /
// direction is formed exactly and rounded toward zero by six pipelined restoring
// dividers, one quotient bit per stage. A new test may enter every cycle while the
// pipeline is not held. The pipeline is the input register, the dividers of
// COORD_WIDTH + FRAC_BITS + 1 stages, then the slab sort, entry/exit reduction and
// output registers. The whole pipeline holds while a result waits on out_ch.ready.
// A miss returns hit = 0 with both distances zero; a zero direction component
// leaves that axis unbounded if the origin lies in the slab and forces a miss
// otherwise. Distances saturate to the coordinate format.
module ray_box_slab_intersection
  import rbs_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  rbs_in_if.sink  in_ch,
  rbs_out_if.source out_ch
);
  localparam int W  = COORD_WIDTH;
  localparam int QW = COORD_WIDTH + FRAC_BITS + 1;  // quotient magnitude width
  localparam int TW = QW + 2;                        // signed distance width
  localparam bit NEED_CAP = (QW > 62);
  localparam logic [QW-1:0] QCAP = QW'(64'h4000_0000_0000_0000);
  localparam logic signed [TW-1:0] POS_INF = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] NEG_INF = -POS_INF;
  localparam logic signed [TW-1:0] OMAX = TW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [TW-1:0] OMIN = -OMAX - TW'(1);

  // per-item flags that ride alongside the dividers
  typedef struct packed {
    logic [NUM_AXES-1:0] neg_a;
    logic [NUM_AXES-1:0] neg_b;
    logic [NUM_AXES-1:0] zero;
    logic                miss;
  } side_t;

  logic en;
  logic out_valid_r;

  // whole pipe advances when the output register is free or being drained
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage 0: slab differences and magnitudes ----------------
  logic signed [W-1:0] o_c [NUM_AXES];
  logic signed [W-1:0] d_c [NUM_AXES];
  logic signed [W-1:0] lo_c [NUM_AXES];
  logic signed [W-1:0] hi_c [NUM_AXES];

  always_comb begin
    o_c[0] = in_ch.origin_x;   o_c[1] = in_ch.origin_y;   o_c[2] = in_ch.origin_z;
    d_c[0] = in_ch.dir_x;      d_c[1] = in_ch.dir_y;      d_c[2] = in_ch.dir_z;
    lo_c[0] = in_ch.box_min_x; lo_c[1] = in_ch.box_min_y; lo_c[2] = in_ch.box_min_z;
    hi_c[0] = in_ch.box_max_x; hi_c[1] = in_ch.box_max_y; hi_c[2] = in_ch.box_max_z;
  end

  logic [QW-1:0] num_a_r [NUM_AXES];
  logic [QW-1:0] num_b_r [NUM_AXES];
  logic [W-1:0]  den_r [NUM_AXES];
  side_t         side0_r;
  logic          v0_r;

  side_t         side0_nxt;
  logic [QW-1:0] num_a_nxt [NUM_AXES];
  logic [QW-1:0] num_b_nxt [NUM_AXES];
  logic [W-1:0]  den_nxt [NUM_AXES];

  always_comb begin
    logic signed [W:0] a, b;
    logic signed [W-1:0] smin, smax;
    logic inslab;
    side0_nxt = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      a = $signed({lo_c[k][W-1], lo_c[k]}) - $signed({o_c[k][W-1], o_c[k]});
      b = $signed({hi_c[k][W-1], hi_c[k]}) - $signed({o_c[k][W-1], o_c[k]});
      num_a_nxt[k] = {(a[W] ? (W+1)'(-a) : (W+1)'(a)), {FRAC_BITS{1'b0}}};
      num_b_nxt[k] = {(b[W] ? (W+1)'(-b) : (W+1)'(b)), {FRAC_BITS{1'b0}}};
      side0_nxt.zero[k] = (d_c[k] == '0);
      // zero direction: divide by one to keep the divider busy with harmless data
      den_nxt[k] = side0_nxt.zero[k] ? W'(1) :
                   (d_c[k][W-1] ? W'(-d_c[k]) : W'(d_c[k]));
      side0_nxt.neg_a[k] = a[W] ^ d_c[k][W-1];
      side0_nxt.neg_b[k] = b[W] ^ d_c[k][W-1];
      // inverted corners act as swapped bounds
      smin = (lo_c[k] < hi_c[k]) ? lo_c[k] : hi_c[k];
      smax = (lo_c[k] < hi_c[k]) ? hi_c[k] : lo_c[k];
      inslab = (o_c[k] >= smin) && (o_c[k] <= smax);
      if (side0_nxt.zero[k] && !inslab) begin
        side0_nxt.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_a_r <= num_a_nxt;
      num_b_r <= num_b_nxt;
      den_r   <= den_nxt;
      side0_r <= side0_nxt;
    end
  end

  // ---------------- dividers ----------------
  logic [QW-1:0] qa [NUM_AXES];
  logic [QW-1:0] qb [NUM_AXES];

  genvar g;
  generate
    for (g = 0; g < NUM_AXES; g++) begin : g_axis
      rbs_div #(.NUM_WIDTH(QW), .DEN_WIDTH(W)) u_div_a (
        .clk(clk), .en(en), .num(num_a_r[g]), .den(den_r[g]), .quo(qa[g])
      );
      rbs_div #(.NUM_WIDTH(QW), .DEN_WIDTH(W)) u_div_b (
        .clk(clk), .en(en), .num(num_b_r[g]), .den(den_r[g]), .quo(qb[g])
      );
    end
  endgenerate

  // flags and valid delayed to match divider depth
  side_t side_dly_r [QW];
  logic  v_dly_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) begin
        v_dly_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_dly_r[0] <= v0_r;
      for (int k = 1; k < QW; k++) begin
        v_dly_r[k] <= v_dly_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly_r[0] <= side0_r;
      for (int k = 1; k < QW; k++) begin
        side_dly_r[k] <= side_dly_r[k-1];
      end
    end
  end

  // ---------------- stage A: sign, cap, near/far per axis ----------------
  side_t sa;
  assign sa = side_dly_r[QW-1];

  logic signed [TW-1:0] near_r [NUM_AXES];
  logic signed [TW-1:0] far_r [NUM_AXES];
  logic                 miss_a_r;
  logic                 va_r;
  logic signed [TW-1:0] near_nxt [NUM_AXES];
  logic signed [TW-1:0] far_nxt [NUM_AXES];

  always_comb begin
    logic [QW-1:0] ma, mb;
    logic signed [TW-1:0] t1, t2;
    for (int k = 0; k < NUM_AXES; k++) begin
      ma = (NEED_CAP && (qa[k] > QCAP)) ? QCAP : qa[k];
      mb = (NEED_CAP && (qb[k] > QCAP)) ? QCAP : qb[k];
      t1 = sa.neg_a[k] ? -$signed(TW'(ma)) : $signed(TW'(ma));
      t2 = sa.neg_b[k] ? -$signed(TW'(mb)) : $signed(TW'(mb));
      if (sa.zero[k]) begin
        near_nxt[k] = NEG_INF;
        far_nxt[k]  = POS_INF;
      end else begin
        near_nxt[k] = (t1 < t2) ? t1 : t2;
        far_nxt[k]  = (t1 < t2) ? t2 : t1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= v_dly_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_r   <= near_nxt;
      far_r    <= far_nxt;
      miss_a_r <= sa.miss;
    end
  end

  // ---------------- stage B: entry/exit reduction and hit decision ----------------
  logic signed [TW-1:0] entry_r, exit_r;
  logic                 hit_b_r;
  logic                 vb_r;
  logic signed [TW-1:0] entry_nxt, exit_nxt;
  logic                 hit_b_nxt;

  always_comb begin
    entry_nxt = NEG_INF;
    exit_nxt  = POS_INF;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (near_r[k] > entry_nxt) begin
        entry_nxt = near_r[k];
      end
      if (far_r[k] < exit_nxt) begin
        exit_nxt = far_r[k];
      end
    end
    hit_b_nxt = !miss_a_r && !(exit_nxt < 0) && !(entry_nxt > exit_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_r <= entry_nxt;
      exit_r  <= exit_nxt;
      hit_b_r <= hit_b_nxt;
    end
  end

  // ---------------- output register: saturation ----------------
  logic                out_hit_r;
  logic signed [W-1:0] out_entry_r, out_exit_r;
  logic signed [W-1:0] sat_entry, sat_exit;

  always_comb begin
    sat_entry = (entry_r > OMAX) ? W'(OMAX) : ((entry_r < OMIN) ? W'(OMIN) : W'(entry_r));
    sat_exit  = (exit_r > OMAX) ? W'(OMAX) : ((exit_r < OMIN) ? W'(OMIN) : W'(exit_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r   <= hit_b_r;
      out_entry_r <= hit_b_r ? sat_entry : '0;
      out_exit_r  <= hit_b_r ? sat_exit : '0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.hit     = out_hit_r;
  assign out_ch.t_entry = out_entry_r;
  assign out_ch.t_exit  = out_exit_r;
endmodule

@@ rtl/rbs_checker.sv @@
`include "assert_macros.svh"

module rbs_checker
  import rbs_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic signed [COORD_WIDTH-1:0] out_t_entry,
  input logic signed [COORD_WIDTH-1:0] out_t_exit
);
  // result held until transfer
  `RBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // a stalled result keeps its payload
  `RBS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                   $stable(out_hit) && $stable(out_t_entry) && $stable(out_t_exit))
  // a miss carries zero distances
  `RBS_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_hit,
                  out_t_entry == '0 && out_t_exit == '0)
  // a hit never enters after it exits, and exits ahead of the origin
  `RBS_ASSERT_NOW(a_hit_order, clk, rst_n, out_valid && out_hit,
                  out_t_entry <= out_t_exit && out_t_exit >= 0)
  // input side never blocks while the output register is empty
  `RBS_ASSERT_NOW(a_ready_free, clk, rst_n, !out_valid, in_ready)
endmodule

bind ray_box_slab_intersection rbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_hit(out_ch.hit),
  .out_t_entry(out_ch.t_entry),
  .out_t_exit(out_ch.t_exit)
);

@@ test/testbench.sv @@
module testbench;
  import rbs_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = CW + FB + 5;
  localparam int IDLE_LIMIT = 20000;
  localparam longint WIDE_POS = 64'sh7fff_ffff_ffff_ffff;
  localparam longint WIDE_NEG = -64'sh7fff_ffff_ffff_ffff;
  localparam longint QCAP = 64'sh4000_0000_0000_0000;

  typedef struct {
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic signed [CW-1:0] bmin [3];
    logic signed [CW-1:0] bmax [3];
  } ray_box_t;

  typedef struct {
    logic hit;
    logic signed [CW-1:0] t_entry;
    logic signed [CW-1:0] t_exit;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rbs_in_if #(.COORD_WIDTH(CW)) in_ch ();
  rbs_out_if #(.COORD_WIDTH(CW)) out_ch ();

  ray_box_slab_intersection #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // expected intersections, oldest first
  hit_rec_t pending_hits[$];
  int mismatch_cnt = 0;
  int result_cnt = 0;
  int hit_cnt = 0;
  int sent_cnt = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  // sender burst shaping
  int burst_left = 0;

  // exact (num * 2^FB) / den rounded toward zero, capped at 2^62
  function automatic longint slab_quot(longint num, longint den);
    logic [63:0] n, d, q, r;
    bit neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    neg = (num < 0) != (den < 0);
    for (int i = 0; i < FB; i++) begin
      if (q >= (QCAP >> 1)) begin
        q = QCAP;
        break;
      end
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    if (q > QCAP) q = QCAP;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [CW-1:0] clamp_dist(longint v);
    longint mx, mn;
    mx = (longint'(1) <<< (CW - 1)) - 1;
    mn = -mx - 1;
    if (v > mx) v = mx;
    if (v < mn) v = mn;
    return v[CW-1:0];
  endfunction

  function automatic hit_rec_t predict_hit(ray_box_t rb);
    hit_rec_t res;
    longint entry, leave, o, dr, lo, hi, t1, t2, nr, fr;
    bit ok;
    entry = WIDE_NEG;
    leave = WIDE_POS;
    ok = 1'b1;
    for (int k = 0; k < NUM_AXES; k++) begin
      o = rb.org[k];
      dr = rb.dir[k];
      lo = rb.bmin[k];
      hi = rb.bmax[k];
      if (dr == 0) begin
        // parallel ray: inside slab means unbounded, else miss
        if (o < ((lo < hi) ? lo : hi) || o > ((lo < hi) ? hi : lo)) begin
          ok = 1'b0;
          continue;
        end
        nr = WIDE_NEG;
        fr = WIDE_POS;
      end else begin
        t1 = slab_quot(lo - o, dr);
        t2 = slab_quot(hi - o, dr);
        nr = (t1 < t2) ? t1 : t2;
        fr = (t1 < t2) ? t2 : t1;
      end
      if (nr > entry) entry = nr;
      if (fr < leave) leave = fr;
    end
    if (ok && (leave < 0 || entry > leave)) ok = 1'b0;
    res.hit = ok;
    res.t_entry = ok ? clamp_dist(entry) : '0;
    res.t_exit = ok ? clamp_dist(leave) : '0;
    return res;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    in_ch.box_min_x = '0; in_ch.box_min_y = '0; in_ch.box_min_z = '0;
    in_ch.box_max_x = '0; in_ch.box_max_y = '0; in_ch.box_max_z = '0;
    out_ch.ready = 1'b0;
  end

  // receiver stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else if (($urandom % 64) < 8) out_ch.ready <= 1'b1;
    else out_ch.ready <= (($urandom % 16) < 11) || (sent_cnt % 300 < 60);
  end

  // result check on every output transfer
  always @(posedge clk) begin
    hit_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_cnt++;
      if (pending_hits.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_hits.pop_front();
        if (out_ch.hit) hit_cnt++;
        if (out_ch.hit !== want.hit || out_ch.t_entry !== want.t_entry ||
            out_ch.t_exit !== want.t_exit) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: hit %0d/%0d entry %0d/%0d exit %0d/%0d (exp/act)",
                     want.hit, out_ch.hit, want.t_entry, out_ch.t_entry,
                     want.t_exit, out_ch.t_exit);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // offer one test and wait for its transfer; valid drops only for a gap
  task automatic send_test(ray_box_t rb, bit no_gap = 1'b0);
    int gap;
    gap = 0;
    if (!no_gap && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
    end
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.origin_x <= rb.org[0]; in_ch.origin_y <= rb.org[1]; in_ch.origin_z <= rb.org[2];
    in_ch.dir_x <= rb.dir[0]; in_ch.dir_y <= rb.dir[1]; in_ch.dir_z <= rb.dir[2];
    in_ch.box_min_x <= rb.bmin[0]; in_ch.box_min_y <= rb.bmin[1];
    in_ch.box_min_z <= rb.bmin[2];
    in_ch.box_max_x <= rb.bmax[0]; in_ch.box_max_y <= rb.bmax[1];
    in_ch.box_max_z <= rb.bmax[2];
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_hits.push_back(predict_hit(rb));
    sent_cnt++;
    @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_word();
    return $urandom;
  endfunction

  // small coordinate, mostly near the origin with a fraction
  function automatic logic signed [CW-1:0] rand_coord();
    return $signed($urandom_range(0, 40 << FB)) - (20 << FB);
  endfunction

  function automatic ray_box_t make_box(logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
    ray_box_t rb;
    for (int k = 0; k < NUM_AXES; k++) begin
      rb.org[k] = '0;
      rb.dir[k] = 1 << FB;
      rb.bmin[k] = lo;
      rb.bmax[k] = hi;
    end
    return rb;
  endfunction

  task automatic test_directed();
    ray_box_t rb;
    logic signed [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    // box ahead on every axis
    rb = make_box(2 << FB, 5 << FB);
    send_test(rb);
    // origin inside box: negative entry
    rb = make_box(-(3 << FB), 3 << FB);
    send_test(rb);
    // box behind the ray
    rb = make_box(-(5 << FB), -(2 << FB));
    send_test(rb);
    // inverted corners act as swapped
    rb = make_box(5 << FB, 2 << FB);
    send_test(rb);
    // negative directions
    rb = make_box(-(5 << FB), -(2 << FB));
    for (int k = 0; k < NUM_AXES; k++) rb.dir[k] = -(1 << FB);
    send_test(rb);
    // all directions zero, origin inside
    rb = make_box(-(1 << FB), 1 << FB);
    for (int k = 0; k < NUM_AXES; k++) rb.dir[k] = '0;
    send_test(rb);
    // zero direction, origin on the slab bound
    rb.bmin[1] = '0;
    send_test(rb);
    // zero direction, origin outside
    rb.bmin[2] = 1; rb.bmax[2] = 2;
    send_test(rb);
    // zero direction, inverted slab containing origin
    rb = make_box(-(1 << FB), 1 << FB);
    rb.dir[0] = '0; rb.bmin[0] = 1 << FB; rb.bmax[0] = -(1 << FB);
    send_test(rb);
    // disjoint slabs: entry beyond exit
    rb = make_box(2 << FB, 3 << FB);
    rb.bmin[1] = 10 << FB; rb.bmax[1] = 11 << FB;
    send_test(rb);
    // saturation: tiny direction, huge box
    rb = make_box(mn, mx);
    for (int k = 0; k < NUM_AXES; k++) rb.dir[k] = 1;
    send_test(rb);
    rb.org[0] = mn; rb.org[1] = mx; rb.dir[2] = mn;
    send_test(rb);
    rb = make_box(mx, mx);
    rb.org[0] = mn; rb.dir[0] = mx; rb.dir[1] = '0; rb.dir[2] = '0;
    rb.bmin[1] = mn; rb.bmin[2] = mn;
    send_test(rb);
    // all ones, then the most negative and most positive values, across every field
    for (int k = 0; k < NUM_AXES; k++) begin
      rb.org[k] = '1; rb.dir[k] = '1; rb.bmin[k] = '1; rb.bmax[k] = '1;
    end
    send_test(rb);
    for (int k = 0; k < NUM_AXES; k++) begin
      rb.org[k] = mn; rb.dir[k] = mn; rb.bmin[k] = mx; rb.bmax[k] = mn;
    end
    send_test(rb);
  endtask

  // mostly rays aimed near a box, some raw noise
  task automatic test_random(int count);
    ray_box_t rb;
    logic signed [CW-1:0] c, h;
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        if ($urandom % 8 == 0) begin
          rb.org[k] = rand_word(); rb.dir[k] = rand_word();
          rb.bmin[k] = rand_word(); rb.bmax[k] = rand_word();
        end else begin
          c = rand_coord();
          h = $urandom_range(1, 4 << FB);
          rb.org[k] = rand_coord();
          rb.bmin[k] = c - h;
          rb.bmax[k] = c + h;
          if ($urandom % 10 == 0) begin
            rb.bmin[k] = c + h; rb.bmax[k] = c - h;
          end
          rb.dir[k] = ($urandom % 10 == 0) ? '0 : c - rb.org[k] + rand_coord() / 8;
          if ($urandom % 12 == 0) rb.org[k] = c;
        end
      end
      send_test(rb);
    end
  endtask

  // receiver stops for a long time while tests keep arriving
  task automatic test_backpressure();
    ray_box_t rb;
    fork
      begin
        hold_off = 1'b1;
        repeat (LATENCY * 4) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int n = 0; n < LATENCY * 2; n++) begin
          rb = make_box(-(1 << FB), (n + 1) << FB);
          rb.dir[n % NUM_AXES] = $urandom_range(1, 8 << FB);
          send_test(rb, 1'b1);
        end
      end
    join
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(500);
    in_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d tests, %0d results, %0d hits, directed cases and a long stall",
             sent_cnt, result_cnt, hit_cnt);
    if (mismatch_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_if.sv
rtl/rbs_div.sv
rtl/ray_box_slab_intersection.sv
rtl/rbs_checker.sv
test/testbench.sv
